[design/cbc_pkg.sv]
// cbc_pkg: shared widths, constants, register indexes and payload types
// for the coverage breakpoint clusterer.
// No dependencies; used by every module of the block.
package cbc_pkg;

    // Field widths
    localparam int unsigned POS_W      = 31;
    localparam int unsigned COV_W      = 32;
    localparam int unsigned SCORE_W    = 5;
    localparam int unsigned RATIO_W    = 16;
    localparam int unsigned CUT_W      = 40;
    localparam int unsigned RUN_W      = 8;
    localparam int unsigned GAP_W      = 16;
    localparam int unsigned CFG_IDX_W  = 8;
    localparam int unsigned CFG_DATA_W = 40;

    // Scores and the Q4.12 unit
    localparam logic [SCORE_W-1:0] SCORE_EDGE = 5'd8;
    localparam logic [SCORE_W-1:0] SCORE_RUN  = 5'd2;
    localparam logic [16:0]        ONE_Q12    = 17'd4096;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RISE_FALL_RATIO = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_CUTOFF      = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_LOW_RUN     = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CLUSTER_GAP     = 8'd3;

    // Configuration reset values
    localparam logic [RATIO_W-1:0] RATIO_RST = 16'd1229;
    localparam logic [CUT_W-1:0]   CUT_RST   = 40'd0;
    localparam logic [RUN_W-1:0]   RUN_RST   = 8'd3;
    localparam logic [GAP_W-1:0]   GAP_RST   = 16'd10;

    typedef struct packed {
        logic [POS_W-1:0] base_position;
        logic [COV_W-1:0] coverage_count;
        logic             contig_end;
    } t_in_item;

    typedef struct packed {
        logic [POS_W-1:0]   breakpoint_position;
        logic [SCORE_W-1:0] breakpoint_score;
        logic               run_last;
    } t_out_item;

    typedef struct packed {
        logic [RATIO_W-1:0] rise_fall_ratio;
        logic [CUT_W-1:0]   low_cutoff;
        logic [RUN_W-1:0]   min_low_run;
        logic [GAP_W-1:0]   cluster_gap;
    } t_cfg;

    // Classified sample handed from front to back
    typedef struct packed {
        logic               single;      // contig of one sample
        logic               is_end;      // last sample of the contig
        logic               pend_valid;  // held position is offered
        logic [POS_W-1:0]   pend_pos;
        logic [SCORE_W-1:0] pend_score;
        logic [POS_W-1:0]   cur_pos;
        logic [SCORE_W-1:0] cur_score;
    } t_cmd;

endpackage

[design/cbc_front.sv]
// cbc_front: accepts coverage samples, tracks low runs and scores rises,
// falls and end-of-run marks, then pushes one command per sample.
// Depends on cbc_pkg.
module cbc_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  cbc_pkg::t_in_item i_in_data,
    output logic            o_in_stall,
    input  cbc_pkg::t_cfg   i_cfg,
    input  logic            i_q_full,
    output logic            o_q_push,
    output cbc_pkg::t_cmd   o_q_data
);
    import cbc_pkg::*;

    localparam int unsigned FAC_W = 17;
    localparam int unsigned HI_W  = COV_W + FAC_W;
    localparam int unsigned LO_W  = COV_W + FAC_W + 1;
    localparam int unsigned Q_W   = COV_W + 12;

    // Per-contig state, updated as samples are taken
    logic [COV_W-1:0]  r_prior;
    logic              r_have_prior;
    logic [RUN_W-1:0]  r_low_run;

    // Stage one: sample plus products of the prior coverage
    logic                   r_s1_valid;
    logic [POS_W-1:0]       r_s1_pos;
    logic [COV_W-1:0]       r_s1_cov;
    logic                   r_s1_end;
    logic                   r_s1_have_prior;
    logic                   r_s1_prior_nz;
    logic                   r_s1_run_mark;
    logic [HI_W-1:0]        r_s1_prod_hi;
    logic signed [LO_W-1:0] r_s1_prod_lo;

    // Held position, waiting for the next sample's end-of-run verdict
    logic [POS_W-1:0]   r_pend_pos;
    logic [SCORE_W-1:0] r_pend_score;

    logic                    w_accept;
    logic                    w_low;
    logic [FAC_W-1:0]        w_hi_fac;
    logic signed [FAC_W-1:0] w_lo_fac;
    logic [HI_W-1:0]         w_prod_hi;
    logic signed [LO_W-1:0]  w_prod_lo;
    logic [Q_W-1:0]          w_cov_q12;
    logic                    w_rise;
    logic                    w_fall;
    logic [SCORE_W-1:0]      w_score;

    assign o_in_stall = r_s1_valid && i_q_full;
    assign w_accept   = i_in_valid && !o_in_stall;
    assign o_q_push   = r_s1_valid && !i_q_full;

    // Low sample test and threshold products
    assign w_low     = {i_in_data.coverage_count, 8'd0} < i_cfg.low_cutoff;
    assign w_hi_fac  = ONE_Q12 + {1'b0, i_cfg.rise_fall_ratio};
    assign w_lo_fac  = $signed(ONE_Q12) - $signed({1'b0, i_cfg.rise_fall_ratio});
    assign w_prod_hi = {{FAC_W{1'b0}}, r_prior} * {{COV_W{1'b0}}, w_hi_fac};
    assign w_prod_lo = $signed({{(FAC_W + 1){1'b0}}, r_prior})
                     * $signed({{(COV_W + 1){w_lo_fac[FAC_W-1]}}, w_lo_fac});

    // Stage two: rise and fall decisions
    assign w_cov_q12 = {r_s1_cov, 12'd0};
    assign w_rise = r_s1_prior_nz ? ({{(HI_W - Q_W){1'b0}}, w_cov_q12} >= r_s1_prod_hi)
                                  : (r_s1_cov != '0);
    assign w_fall = r_s1_prior_nz
                 && (r_s1_prod_lo >= $signed({{(LO_W - Q_W){1'b0}}, w_cov_q12}));

    always_comb begin
        w_score = '0;
        if (r_s1_have_prior) begin
            w_score = (w_rise ? SCORE_EDGE : '0) + (w_fall ? SCORE_EDGE : '0);
        end
    end

    // Command for the back end
    always_comb begin
        o_q_data.single     = r_s1_end && !r_s1_have_prior;
        o_q_data.is_end     = r_s1_end;
        o_q_data.pend_valid = r_s1_have_prior;
        o_q_data.pend_pos   = r_pend_pos;
        o_q_data.pend_score = r_pend_score + (r_s1_run_mark ? SCORE_RUN : '0);
        o_q_data.cur_pos    = r_s1_pos;
        o_q_data.cur_score  = w_score;
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid   <= 1'b0;
            r_prior      <= '0;
            r_have_prior <= 1'b0;
            r_low_run    <= '0;
        end else begin
            if (w_accept) begin
                r_s1_valid <= 1'b1;
            end else if (o_q_push) begin
                r_s1_valid <= 1'b0;
            end
            if (w_accept) begin
                if (i_in_data.contig_end) begin
                    r_prior      <= '0;
                    r_have_prior <= 1'b0;
                    r_low_run    <= '0;
                end else begin
                    r_prior      <= i_in_data.coverage_count;
                    r_have_prior <= 1'b1;
                    if (!w_low) begin
                        r_low_run <= '0;
                    end else if (r_low_run != '1) begin
                        r_low_run <= r_low_run + 1'b1;
                    end
                end
            end
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_pos        <= i_in_data.base_position;
            r_s1_cov        <= i_in_data.coverage_count;
            r_s1_end        <= i_in_data.contig_end;
            r_s1_have_prior <= r_have_prior;
            r_s1_prior_nz   <= (r_prior != '0);
            r_s1_run_mark   <= !w_low && r_have_prior && (r_low_run >= i_cfg.min_low_run);
            r_s1_prod_hi    <= w_prod_hi;
            r_s1_prod_lo    <= w_prod_lo;
        end
        if (o_q_push) begin
            r_pend_pos   <= r_s1_pos;
            r_pend_score <= w_score;
        end
    end

endmodule

[design/cbc_queue.sv]
// cbc_queue: short command queue between the scoring front end and the
// clustering back end.
// Depends on cbc_pkg.
module cbc_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  cbc_pkg::t_cmd i_data,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_valid,
    output cbc_pkg::t_cmd o_data
);
    import cbc_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

[design/cbc_back.sv]
// cbc_back: chains scored positions into clusters and emits each cluster's
// best position, and each one-sample contig, through a registered output stage.
// Depends on cbc_pkg.
module cbc_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [cbc_pkg::GAP_W-1:0] i_cluster_gap,
    input  logic              i_q_valid,
    input  cbc_pkg::t_cmd     i_q_data,
    output logic              o_q_pop,
    output logic              o_out_valid,
    output cbc_pkg::t_out_item o_out_data,
    input  logic              i_out_stall
);
    import cbc_pkg::*;

    typedef enum logic [1:0] {
        PH_FEED_PEND,
        PH_FEED_LAST,
        PH_FLUSH
    } t_phase;

    t_phase             r_phase;
    logic               r_open;
    logic [POS_W-1:0]   r_tail;
    logic [POS_W-1:0]   r_best_pos;
    logic [SCORE_W-1:0] r_best_score;
    logic               r_out_valid;
    t_out_item          r_out_data;

    t_phase             n_phase;
    logic               n_open;
    logic [POS_W-1:0]   n_tail;
    logic [POS_W-1:0]   n_best_pos;
    logic [SCORE_W-1:0] n_best_score;

    logic [POS_W-1:0]   w_f_pos;
    logic [SCORE_W-1:0] w_f_score;
    logic [POS_W-1:0]   w_dist;
    logic               w_join;
    logic               w_emit;
    t_out_item          w_res;
    logic               w_done;
    logic               w_out_free;
    logic               w_step;

    // Distance from the cluster's last candidate
    assign w_dist = (w_f_pos >= r_tail) ? (w_f_pos - r_tail) : (r_tail - w_f_pos);
    assign w_join = r_open && (w_dist <= {{(POS_W - GAP_W){1'b0}}, i_cluster_gap});

    // Phase selection and cluster update
    always_comb begin
        n_phase      = r_phase;
        n_open       = r_open;
        n_tail       = r_tail;
        n_best_pos   = r_best_pos;
        n_best_score = r_best_score;
        w_f_pos      = i_q_data.cur_pos;
        w_f_score    = '0;
        w_emit       = 1'b0;
        w_done       = 1'b0;
        w_res.breakpoint_position = r_best_pos;
        w_res.breakpoint_score    = r_best_score;
        w_res.run_last            = 1'b0;

        unique case (r_phase)
            PH_FEED_PEND: begin
                if (i_q_data.single) begin
                    w_emit = 1'b1;
                    w_done = 1'b1;
                    w_res.breakpoint_position = i_q_data.cur_pos;
                    w_res.breakpoint_score    = '0;
                    w_res.run_last            = 1'b1;
                end else begin
                    if (i_q_data.pend_valid) begin
                        w_f_pos   = i_q_data.pend_pos;
                        w_f_score = i_q_data.pend_score;
                    end
                    w_done         = !i_q_data.is_end;
                    w_res.run_last = !i_q_data.is_end;
                    n_phase        = i_q_data.is_end ? PH_FEED_LAST : PH_FEED_PEND;
                end
            end
            PH_FEED_LAST: begin
                w_f_pos   = i_q_data.cur_pos;
                w_f_score = i_q_data.cur_score;
                n_phase   = PH_FLUSH;
            end
            PH_FLUSH: begin
                w_emit         = r_open;
                w_res.run_last = 1'b1;
                w_done         = 1'b1;
                n_open         = 1'b0;
                n_phase        = PH_FEED_PEND;
            end
            default: begin
                n_phase = PH_FEED_PEND;
            end
        endcase

        // Offer a scored position to the clusterer
        if (w_f_score != '0) begin
            if (w_join) begin
                if (w_f_score > r_best_score) begin
                    n_best_pos   = w_f_pos;
                    n_best_score = w_f_score;
                end
                n_tail = w_f_pos;
            end else begin
                w_emit       = r_open;
                n_open       = 1'b1;
                n_best_pos   = w_f_pos;
                n_best_score = w_f_score;
                n_tail       = w_f_pos;
            end
        end
    end

    assign w_out_free = !r_out_valid || !i_out_stall;
    assign w_step     = i_q_valid && (!w_emit || w_out_free);
    assign o_q_pop    = w_step && w_done;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    // Phase, cluster state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_FEED_PEND;
            r_open      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_step) begin
                r_phase      <= n_phase;
                r_open       <= n_open;
                r_tail       <= n_tail;
                r_best_pos   <= n_best_pos;
                r_best_score <= n_best_score;
            end
            if (w_out_free) begin
                r_out_valid <= w_step && w_emit;
            end
            if (w_step && w_emit) begin
                r_out_data <= w_res;
            end
        end
    end

endmodule

[design/coverage_breakpoint_clusterer.sv]
// coverage_breakpoint_clusterer: top level; configuration registers, front
// end, command queue and clustering back end.
// Depends on cbc_pkg, cbc_front, cbc_queue, cbc_back.
//
//   channel | direction | handshake                 | payload
//   --------+-----------+---------------------------+------------------------
//   in      | in        | i_in_valid / o_in_stall   | i_in_data  (t_in_item)
//   out     | out       | o_out_valid / i_out_stall | o_out_data (t_out_item)
//   cfg     | in        | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// One sample per cycle while the back end keeps up. A taken sample waits in
// the front's stage-one register until the queue has room, then passes the
// queue and the back end's output register. The last sample of a multi-sample
// contig takes the back end through held position, last position and cluster flush.
// Reset is synchronous and active low; configuration returns to its defaults.
// The queue of QUEUE_DEPTH entries lets the front keep taking samples while
// the output is stalled; the input stalls once it fills.
module coverage_breakpoint_clusterer #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    input  cbc_pkg::t_in_item                 i_in_data,
    output logic                              o_in_stall,
    output logic                              o_out_valid,
    output cbc_pkg::t_out_item                o_out_data,
    input  logic                              i_out_stall,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [cbc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [cbc_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import cbc_pkg::*;

    t_cfg r_cfg;
    logic w_cfg_wr;
    logic w_q_push;
    logic w_q_full;
    logic w_q_pop;
    logic w_q_valid;
    t_cmd w_q_in;
    t_cmd w_q_out;

    // Configuration registers
    assign o_cfg_ready = 1'b1;
    assign w_cfg_wr    = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rise_fall_ratio <= RATIO_RST;
            r_cfg.low_cutoff      <= CUT_RST;
            r_cfg.min_low_run     <= RUN_RST;
            r_cfg.cluster_gap     <= GAP_RST;
        end else if (w_cfg_wr) begin
            unique case (i_cfg_index)
                CFG_RISE_FALL_RATIO: r_cfg.rise_fall_ratio <= i_cfg_data[RATIO_W-1:0];
                CFG_LOW_CUTOFF:      r_cfg.low_cutoff      <= i_cfg_data[CUT_W-1:0];
                CFG_MIN_LOW_RUN:     r_cfg.min_low_run     <= i_cfg_data[RUN_W-1:0];
                CFG_CLUSTER_GAP:     r_cfg.cluster_gap     <= i_cfg_data[GAP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Scoring front end
    cbc_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_data  (i_in_data),
        .o_in_stall (o_in_stall),
        .i_cfg      (r_cfg),
        .i_q_full   (w_q_full),
        .o_q_push   (w_q_push),
        .o_q_data   (w_q_in)
    );

    // Command queue
    cbc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_q_push),
        .i_data  (w_q_in),
        .o_full  (w_q_full),
        .i_pop   (w_q_pop),
        .o_valid (w_q_valid),
        .o_data  (w_q_out)
    );

    // Clustering back end
    cbc_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cluster_gap (r_cfg.cluster_gap),
        .i_q_valid     (w_q_valid),
        .i_q_data      (w_q_out),
        .o_q_pop       (w_q_pop),
        .o_out_valid   (o_out_valid),
        .o_out_data    (o_out_data),
        .i_out_stall   (i_out_stall)
    );

`ifndef SYNTHESIS
    // Back end only consumes commands that are present
    a_pop_has_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_pop |-> w_q_valid)
        else $error("command popped from an empty queue");

    // A zero score only comes from a one-sample contig, which is always last
    a_zero_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_data.breakpoint_score == '0)) |-> o_out_data.run_last)
        else $error("zero-score result not marked last");

    // Scores are sums of 8 and 2, so never odd and never above 18
    a_score_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (!o_out_data.breakpoint_score[0]
                         && (o_out_data.breakpoint_score <= 5'd18)))
        else $error("result score out of form");
`endif

endmodule

[dv/coverage_breakpoint_clusterer_tb.sv]
// Self-checking testbench for coverage_breakpoint_clusterer: directed and
// random coverage contigs, with a scoreboard that predicts every breakpoint.
// Depends on cbc_pkg and the coverage_breakpoint_clusterer RTL.
`timescale 1ns / 100ps

module coverage_breakpoint_clusterer_tb;
    import cbc_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 400000;
    localparam int unsigned RANDOM_ITEMS  = 180;
    localparam int unsigned SETTLE_CYCLES = 20;
    localparam int unsigned HOLD_CYCLES   = 80;

    // Breakpoint scoreboard: own copy of registers and contig state
    class breakpoint_scoreboard;
        logic [RATIO_W-1:0] ratio_q12;
        logic [CUT_W-1:0]   cutoff_q8;
        logic [RUN_W-1:0]   run_needed;
        logic [GAP_W-1:0]   gap_limit;

        logic [COV_W-1:0]   prev_cov;
        logic               seen_first;
        logic [RUN_W-1:0]   low_count;
        logic               held_ok;
        logic [POS_W-1:0]   held_pos;
        logic [SCORE_W-1:0] held_score;
        logic               clus_open;
        logic [POS_W-1:0]   clus_tail;
        logic [POS_W-1:0]   top_pos;
        logic [SCORE_W-1:0] top_score;

        t_out_item step_out[$];
        t_out_item expected_breakpoints[$];
        int unsigned errors;

        function new();
            ratio_q12  = RATIO_RST;
            cutoff_q8  = CUT_RST;
            run_needed = RUN_RST;
            gap_limit  = GAP_RST;
            errors     = 0;
            clear_contig();
        endfunction

        function void clear_contig();
            prev_cov   = '0;
            seen_first = 1'b0;
            low_count  = '0;
            held_ok    = 1'b0;
            held_pos   = '0;
            held_score = '0;
            clus_open  = 1'b0;
            clus_tail  = '0;
            top_pos    = '0;
            top_score  = '0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
            case (idx)
                CFG_RISE_FALL_RATIO: ratio_q12  = val[RATIO_W-1:0];
                CFG_LOW_CUTOFF:      cutoff_q8  = val[CUT_W-1:0];
                CFG_MIN_LOW_RUN:     run_needed = val[RUN_W-1:0];
                CFG_CLUSTER_GAP:     gap_limit  = val[GAP_W-1:0];
                default: ;
            endcase
        endfunction

        function void emit(logic [POS_W-1:0] pos, logic [SCORE_W-1:0] score);
            t_out_item r;
            r.breakpoint_position = pos;
            r.breakpoint_score    = score;
            r.run_last            = 1'b0;
            step_out = {step_out, r};
        endfunction

        // Chain a scored position into the open cluster, or close it
        function void offer(logic [POS_W-1:0] pos, logic [SCORE_W-1:0] score);
            logic [POS_W-1:0] gap_dist;
            if (score == 0) return;
            if (clus_open) begin
                gap_dist = (pos >= clus_tail) ? pos - clus_tail : clus_tail - pos;
                if (gap_dist <= {15'd0, gap_limit}) begin
                    if (score > top_score) begin
                        top_score = score;
                        top_pos   = pos;
                    end
                    clus_tail = pos;
                    return;
                end
                emit(top_pos, top_score);
            end
            clus_open = 1'b1;
            top_pos   = pos;
            top_score = score;
            clus_tail = pos;
        endfunction

        // Predict the breakpoints caused by one accepted sample
        function void predict_breakpoints(t_in_item it);
            logic               low;
            logic               rise;
            logic               fall;
            logic [SCORE_W-1:0] now_score;
            logic [SCORE_W-1:0] ps;
            longint unsigned    pw;
            longint unsigned    cw;
            longint             sp;
            longint             sr;
            longint             sc;
            step_out.delete();
            now_score = '0;
            low = {it.coverage_count, 8'h00} < cutoff_q8;
            if (it.contig_end && !seen_first) begin
                // contig of a single sample
                emit(it.base_position, '0);
            end else begin
                if (seen_first) begin
                    pw = prev_cov;
                    cw = it.coverage_count;
                    if (pw != 0) begin
                        rise = (cw * 4096) >= (pw * (4096 + ratio_q12));
                        sp = pw;
                        sr = ratio_q12;
                        sc = cw * 4096;
                        fall = (sp * (64'sd4096 - sr)) >= sc;
                    end else begin
                        rise = (cw != 0);
                        fall = 1'b0;
                    end
                    if (rise) now_score += SCORE_EDGE;
                    if (fall) now_score += SCORE_EDGE;
                end
                if (held_ok) begin
                    ps = held_score;
                    if (!low && low_count >= run_needed) ps += SCORE_RUN;
                    offer(held_pos, ps);
                end
                held_ok    = 1'b1;
                held_pos   = it.base_position;
                held_score = now_score;
                if (low) begin
                    if (low_count != 8'hFF) low_count++;
                end else begin
                    low_count = '0;
                end
                prev_cov   = it.coverage_count;
                seen_first = 1'b1;
                if (it.contig_end) begin
                    offer(held_pos, held_score);
                    if (clus_open) emit(top_pos, top_score);
                end
            end
            if (it.contig_end) clear_contig();
            if (step_out.size() > 0) step_out[$].run_last = 1'b1;
            foreach (step_out[i]) expected_breakpoints = {expected_breakpoints, step_out[i]};
        endfunction

        function void check_breakpoint(t_out_item got);
            t_out_item want;
            if (expected_breakpoints.size() == 0) begin
                $display("%0t: unexpected breakpoint pos=%0d score=%0d last=%0b", $time,
                         got.breakpoint_position, got.breakpoint_score, got.run_last);
                errors++;
                return;
            end
            want = expected_breakpoints.pop_front();
            if (got.breakpoint_position !== want.breakpoint_position) begin
                $display("%0t: breakpoint_position expected %0d actual %0d", $time,
                         want.breakpoint_position, got.breakpoint_position);
                errors++;
            end
            if (got.breakpoint_score !== want.breakpoint_score) begin
                $display("%0t: breakpoint_score expected %0d actual %0d", $time,
                         want.breakpoint_score, got.breakpoint_score);
                errors++;
            end
            if (got.run_last !== want.run_last) begin
                $display("%0t: run_last expected %0b actual %0b", $time,
                         want.run_last, got.run_last);
                errors++;
            end
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  in_valid;
    t_in_item              in_data;
    logic                  in_stall;
    logic                  out_valid;
    t_out_item             out_data;
    logic                  out_stall;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    breakpoint_scoreboard sb;
    bit                   hold_off_req;
    bit                   burst_mode;
    int unsigned          cycles;

    coverage_breakpoint_clusterer dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .i_in_data   (in_data),
        .o_in_stall  (in_stall),
        .o_out_valid (out_valid),
        .o_out_data  (out_data),
        .i_out_stall (out_stall),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Cycle limit
    initial begin
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("[coverage_breakpoint_clusterer] ERROR");
        $finish;
    end

    // Result side: random stall per request, one long hold-off on demand
    initial begin
        int unsigned n;
        out_stall = 1'b0;
        wait (sb != null);
        forever begin
            @(negedge i_clk);
            if (hold_off_req) begin
                out_stall = 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_off_req = 1'b0;
            end else begin
                n = burst_mode ? 0 : $urandom_range(0, 5);
                if (n > 0) begin
                    out_stall = 1'b1;
                    repeat (n) @(negedge i_clk);
                end
            end
            out_stall = 1'b0;
            do @(posedge i_clk); while (out_valid !== 1'b1);
            sb.check_breakpoint(out_data);
        end
    end

    // Offer one sample; entered and left at a falling edge
    task automatic push_sample(logic [POS_W-1:0] pos, logic [COV_W-1:0] cov, logic last);
        int unsigned gap;
        gap = burst_mode ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_data.base_position  = pos;
        in_data.coverage_count = cov;
        in_data.contig_end     = last;
        in_valid = 1'b1;
        do @(posedge i_clk); while (in_stall !== 1'b0);
        sb.predict_breakpoints(in_data);
        @(negedge i_clk);
    endtask

    // Stop offering and wait for the block to go idle
    task automatic settle();
        in_valid = 1'b0;
        while (sb.expected_breakpoints.size() > 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        cfg_index = idx;
        cfg_data  = val;
        cfg_valid = 1'b1;
        do @(posedge i_clk); while (cfg_ready !== 1'b1);
        sb.set_reg(idx, val);
        @(negedge i_clk);
        cfg_valid = 1'b0;
    endtask

    // Random register settings, extremes weighted in
    task automatic shuffle_regs();
        logic [CFG_DATA_W-1:0] v;
        case ($urandom_range(0, 4))
            0:       v = 40'd0;
            1:       v = 40'd65535;
            2:       v = 40'd4096;
            3:       v = {24'd0, 16'($urandom)};
            default: v = 40'd1229;
        endcase
        write_reg(CFG_RISE_FALL_RATIO, v);
        case ($urandom_range(0, 5))
            0:       v = 40'd0;
            1:       v = 40'hFF_FFFF_FFFF;
            2:       v = {8'($urandom), 32'($urandom)};
            default: v = 40'($urandom_range(0, 120)) * 256 + 40'($urandom_range(0, 255));
        endcase
        write_reg(CFG_LOW_CUTOFF, v);
        case ($urandom_range(0, 4))
            0:       v = 40'd0;
            1:       v = 40'd1;
            2:       v = 40'd255;
            3:       v = 40'($urandom_range(0, 255));
            default: v = 40'($urandom_range(1, 4));
        endcase
        write_reg(CFG_MIN_LOW_RUN, v);
        case ($urandom_range(0, 4))
            0:       v = 40'd0;
            1:       v = 40'd65535;
            2:       v = {24'd0, 16'($urandom)};
            default: v = 40'($urandom_range(1, 40));
        endcase
        write_reg(CFG_CLUSTER_GAP, v);
    endtask

    // One random contig; mostly ascending positions, some disorder as noise
    task automatic random_contig(int unsigned len, ref int unsigned sent);
        logic [POS_W-1:0] pos;
        logic [COV_W-1:0] cov;
        int unsigned      level;
        pos   = ($urandom_range(0, 3) == 0) ? POS_W'($urandom) : POS_W'($urandom_range(0, 5000));
        level = $urandom_range(0, 200);
        for (int unsigned k = 0; k < len; k++) begin
            case ($urandom_range(0, 19))
                0:       pos = pos - POS_W'($urandom_range(0, 30));
                1, 2:    pos = pos + POS_W'($urandom_range(21, 3000));
                default: pos = pos + POS_W'($urandom_range(1, 20));
            endcase
            if ($urandom_range(0, 5) == 0) level = $urandom_range(0, 200);
            case ($urandom_range(0, 11))
                0:       cov = '0;
                1:       cov = $urandom;
                2:       cov = '1;
                3:       cov = COV_W'(level * 2);
                4:       cov = COV_W'(level / 2);
                default: cov = COV_W'(level + $urandom_range(0, 20));
            endcase
            push_sample(pos, cov, k == len - 1);
            sent++;
        end
    endtask

    initial begin
        int unsigned sent;
        i_rst_n      = 1'b0;
        in_valid     = 1'b0;
        in_data      = '0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        hold_off_req = 1'b0;
        burst_mode   = 1'b0;
        sent         = 0;
        sb = new();
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        repeat (SETTLE_CYCLES) @(negedge i_clk);

        // Single-sample contigs at the field extremes
        push_sample('0, '0, 1'b1);
        push_sample('1, '1, 1'b1);
        // Rise from zero coverage, flat, fall, jump to full scale
        push_sample(POS_W'(100), COV_W'(0), 1'b0);
        push_sample(POS_W'(101), COV_W'(50), 1'b0);
        push_sample(POS_W'(102), COV_W'(50), 1'b0);
        push_sample(POS_W'(103), COV_W'(10), 1'b0);
        push_sample(POS_W'(104), '1, 1'b0);
        push_sample(POS_W'(200), '1, 1'b1);
        settle();

        // Zero ratio: equal coverage is both rise and fall; disordered positions
        write_reg(CFG_RISE_FALL_RATIO, 40'd0);
        write_reg(CFG_CLUSTER_GAP, 40'd65535);
        push_sample(POS_W'(5), COV_W'(7), 1'b0);
        push_sample(POS_W'(6), COV_W'(7), 1'b0);
        push_sample(POS_W'(3), COV_W'(7), 1'b0);
        push_sample(POS_W'(3), COV_W'(7), 1'b1);
        settle();

        // Largest ratio, zero gap, zero minimum run: any non-low sample marks
        write_reg(CFG_RISE_FALL_RATIO, 40'd65535);
        write_reg(CFG_LOW_CUTOFF, 40'd20 * 256);
        write_reg(CFG_MIN_LOW_RUN, 40'd0);
        write_reg(CFG_CLUSTER_GAP, 40'd0);
        push_sample(POS_W'(10), COV_W'(30), 1'b0);
        push_sample(POS_W'(11), COV_W'(30), 1'b0);
        push_sample(POS_W'(12), COV_W'(5), 1'b0);
        push_sample(POS_W'(13), COV_W'(30), 1'b1);
        settle();

        // Low run that ends, then one still going at contig end
        write_reg(CFG_RISE_FALL_RATIO, 40'd1229);
        write_reg(CFG_MIN_LOW_RUN, 40'd3);
        push_sample(POS_W'(20), COV_W'(5), 1'b0);
        push_sample(POS_W'(21), COV_W'(5), 1'b0);
        push_sample(POS_W'(22), COV_W'(5), 1'b0);
        push_sample(POS_W'(23), COV_W'(40), 1'b0);
        push_sample(POS_W'(24), COV_W'(5), 1'b0);
        push_sample(POS_W'(25), COV_W'(5), 1'b0);
        push_sample(POS_W'(26), COV_W'(5), 1'b0);
        push_sample(POS_W'(27), COV_W'(5), 1'b1);
        settle();

        // Back-pressure: result side holds off while nearly every sample closes a cluster
        hold_off_req = 1'b1;
        for (int unsigned k = 0; k < 16; k++) begin
            push_sample(POS_W'(1000 * (k + 1)), (k % 2 == 0) ? COV_W'(10) : COV_W'(200),
                        k == 15);
        end
        settle();

        // Random contigs with register changes between them, only when idle
        while (sent < RANDOM_ITEMS) begin
            if ($urandom_range(0, 2) == 0) begin
                settle();
                shuffle_regs();
            end
            burst_mode = ($urandom_range(0, 5) == 0);
            random_contig(($urandom_range(0, 4) == 0) ? 1 : $urandom_range(2, 12), sent);
            if ($urandom_range(0, 2) == 0) settle();
        end
        burst_mode = 1'b0;
        settle();

        if (sb.errors == 0) begin
            $display("[coverage_breakpoint_clusterer] OK");
        end else begin
            $display("[coverage_breakpoint_clusterer] ERROR");
        end
        $finish;
    end

endmodule
